@@ rtl/rfp_pkg.sv @@
// shared types and constants for the radar frame parser
package rfp_pkg;

    localparam int MAX_FRAME_DEF = 40;

    // bytes 0..18 hold every fixed-position field of a frame
    localparam int FIELD_BYTES   = 19;
    localparam int MIN_DATA_LEN  = 19;
    localparam int LEN_OVERHEAD  = 10;
    localparam int LEN_CHECK_POS = 8;
    localparam int ENERGY_MAX    = 100;

    localparam int EVENT_W = 3;
    localparam int ALEN_W  = 6;

    typedef logic [EVENT_W-1:0] t_event;

    localparam t_event EV_NONE    = 3'd0;
    localparam t_event EV_ACCEPT  = 3'd1;
    localparam t_event EV_ACK     = 3'd2;
    localparam t_event EV_REJECT  = 3'd3;
    localparam t_event EV_TOOLONG = 3'd4;
    localparam t_event EV_OVERRUN = 3'd5;

    // data frame header and tail
    localparam logic [7:0] DATA_H0 = 8'hF4;
    localparam logic [7:0] DATA_H1 = 8'hF3;
    localparam logic [7:0] DATA_H2 = 8'hF2;
    localparam logic [7:0] DATA_H3 = 8'hF1;
    localparam logic [7:0] DATA_T0 = 8'hF8;
    localparam logic [7:0] DATA_T1 = 8'hF7;
    localparam logic [7:0] DATA_T2 = 8'hF6;
    localparam logic [7:0] DATA_T3 = 8'hF5;

    // ack frame header and tail
    localparam logic [7:0] ACK_H0 = 8'hFD;
    localparam logic [7:0] ACK_H1 = 8'hFC;
    localparam logic [7:0] ACK_H2 = 8'hFB;
    localparam logic [7:0] ACK_H3 = 8'hFA;
    localparam logic [7:0] ACK_T0 = 8'h04;
    localparam logic [7:0] ACK_T1 = 8'h03;
    localparam logic [7:0] ACK_T2 = 8'h02;
    localparam logic [7:0] ACK_T3 = 8'h01;

    // payload markers at bytes 6, 7, 17, 18
    localparam logic [7:0] MARK_6  = 8'h02;
    localparam logic [7:0] MARK_7  = 8'hAA;
    localparam logic [7:0] MARK_17 = 8'h55;
    localparam logic [7:0] MARK_18 = 8'h00;

    typedef struct packed {
        logic [7:0]        kind;
        logic [15:0]       moving_dist;
        logic [7:0]        moving_energy;
        logic [15:0]       still_dist;
        logic [7:0]        still_energy;
        logic [ALEN_W-1:0] length;
    } t_target;

endpackage

@@ rtl/rfp_byte_if.sv @@
// input channel: one received serial byte per beat
interface rfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/rfp_result_if.sv @@
// output channel: one parse result per beat
interface rfp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  target_kind;
    logic [15:0] moving_distance;
    logic [6:0]  moving_energy;
    logic [15:0] still_distance;
    logic [7:0]  still_energy;
    logic        presence;
    logic        moving_seen;
    logic        still_seen;
    logic [5:0]  accepted_length;

    modport source (
        output valid, output event_res, output target_kind, output moving_distance,
        output moving_energy, output still_distance, output still_energy,
        output presence, output moving_seen, output still_seen, output accepted_length,
        input ready
    );
    modport sink (
        input valid, input event_res, input target_kind, input moving_distance,
        input moving_energy, input still_distance, input still_energy,
        input presence, input moving_seen, input still_seen, input accepted_length,
        output ready
    );
endinterface

@@ rtl/radar_frame_parser.sv @@
// top level of the radar frame parser with its byte and result channels

// Takes one received sensor byte per beat and returns exactly one result beat
// for it: an event code plus the target registers as they stand after that
// byte. A new byte is taken every clock cycle unless a result that is not taken
// holds it back; each byte passes through the input register and then the
// result register. The input stays open while a result waits, as long as the
// input register is empty or moves on. Fixed-position frame fields are kept
// in a small byte store and the tail is matched against the last four bytes,
// so all decoding is combinational between the input and result registers.
module radar_frame_parser
    import rfp_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rfp_byte_if.sink     i_byte,
    rfp_result_if.source o_result
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_event     r_out_event;

    logic    out_free, step;
    t_event  core_event;
    t_target tgt;

    assign out_free     = !r_out_valid || o_result.ready;
    assign step         = r_in_valid && out_free;
    assign i_byte.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (out_free) begin
                r_out_valid <= step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.rx_byte;
        end
        if (step) begin
            r_out_event <= core_event;
        end
    end

    rfp_parse_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_event  (core_event),
        .o_target (tgt)
    );

    // target registers only change when a beat moves into the result register
    assign o_result.valid           = r_out_valid;
    assign o_result.event_res       = r_out_event;
    assign o_result.target_kind     = tgt.kind;
    assign o_result.moving_distance = tgt.moving_dist;
    assign o_result.moving_energy   = (tgt.moving_energy > 8'(ENERGY_MAX))
                                    ? 7'(ENERGY_MAX) : tgt.moving_energy[6:0];
    assign o_result.still_distance  = tgt.still_dist;
    assign o_result.still_energy    = tgt.still_energy;
    assign o_result.presence        = tgt.kind != '0;
    assign o_result.moving_seen     = tgt.kind[0] && tgt.moving_dist != '0
                                   && tgt.moving_energy != '0;
    assign o_result.still_seen      = tgt.kind[1] && tgt.still_dist != '0
                                   && tgt.still_energy != '0;
    assign o_result.accepted_length = tgt.length;

endmodule

@@ rtl/rfp_parse_core.sv @@
// frame state, field capture and target registers, one byte per step
module rfp_parse_core
    import rfp_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_event     o_event,
    output t_target    o_target
);

    localparam int PW  = $clog2(MAX_FRAME + 1);
    localparam int SIW = $clog2(FIELD_BYTES);

    logic [PW-1:0] r_pos, n_pos;
    logic          r_in_frame, n_in_frame;
    logic          r_is_ack, n_is_ack;
    t_target       r_tgt, n_tgt;
    logic [7:0]    r_store [FIELD_BYTES];
    logic [7:0]    r_b1, r_b2, r_b3;

    logic [7:0]     view [FIELD_BYTES];
    logic           w_en;
    logic [SIW-1:0] w_idx;
    logic [PW-1:0]  pos_inc;
    logic [16:0]    len_total;
    logic           hdr_ok, tail_ok, data_ok, start;

    always_comb begin
        w_idx = r_in_frame ? r_pos[SIW-1:0] : '0;
        if (r_in_frame) begin
            w_en = (r_pos < PW'(FIELD_BYTES)) && (r_pos < PW'(MAX_FRAME)) && (r_pos != '0);
        end else begin
            w_en = start;
        end
        // store contents with the current byte already in place
        for (int i = 0; i < FIELD_BYTES; i++) begin
            view[i] = (w_en && w_idx == SIW'(i)) ? i_byte : r_store[i];
        end
    end

    assign start     = (i_byte == DATA_H0) || (i_byte == ACK_H0);
    assign pos_inc   = r_pos + PW'(1);
    assign len_total = {1'b0, view[5], view[4]} + 17'(LEN_OVERHEAD);

    always_comb begin
        if (r_is_ack) begin
            hdr_ok  = view[0] == ACK_H0 && view[1] == ACK_H1
                   && view[2] == ACK_H2 && view[3] == ACK_H3;
            tail_ok = r_b3 == ACK_T0 && r_b2 == ACK_T1 && r_b1 == ACK_T2 && i_byte == ACK_T3;
        end else begin
            hdr_ok  = view[0] == DATA_H0 && view[1] == DATA_H1
                   && view[2] == DATA_H2 && view[3] == DATA_H3;
            tail_ok = r_b3 == DATA_T0 && r_b2 == DATA_T1
                   && r_b1 == DATA_T2 && i_byte == DATA_T3;
        end
    end

    assign data_ok = (17'(pos_inc) == len_total) && (pos_inc >= PW'(MIN_DATA_LEN))
                  && view[6] == MARK_6 && view[7] == MARK_7
                  && view[17] == MARK_17 && view[18] == MARK_18;

    always_comb begin
        n_pos      = r_pos;
        n_in_frame = r_in_frame;
        n_is_ack   = r_is_ack;
        n_tgt      = r_tgt;
        o_event    = EV_NONE;
        if (!r_in_frame) begin
            if (start) begin
                n_pos      = PW'(1);
                n_in_frame = 1'b1;
                n_is_ack   = (i_byte == ACK_H0);
            end
        end else if (r_pos >= PW'(MAX_FRAME) || r_pos == '0) begin
            n_pos      = '0;
            n_in_frame = 1'b0;
            o_event    = EV_OVERRUN;
        end else begin
            n_pos      = '0;
            n_in_frame = 1'b0;
            if (pos_inc == PW'(LEN_CHECK_POS) && len_total > 17'(MAX_FRAME)) begin
                o_event = EV_TOOLONG;
            end else if (pos_inc >= PW'(LEN_CHECK_POS) && hdr_ok && tail_ok) begin
                if (r_is_ack) begin
                    o_event = EV_ACK;
                end else if (data_ok) begin
                    o_event             = EV_ACCEPT;
                    n_tgt.kind          = view[8];
                    n_tgt.still_dist    = {view[10], view[9]};
                    n_tgt.moving_energy = view[11];
                    n_tgt.still_energy  = view[14];
                    n_tgt.moving_dist   = {view[16], view[15]};
                    n_tgt.length        = ALEN_W'(pos_inc);
                end else begin
                    o_event = EV_REJECT;
                end
            end else if (pos_inc >= PW'(MAX_FRAME)) begin
                o_event = EV_OVERRUN;
            end else begin
                n_pos      = pos_inc;
                n_in_frame = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_in_frame <= 1'b0;
            r_is_ack   <= 1'b0;
            r_tgt      <= '0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_in_frame <= n_in_frame;
            r_is_ack   <= n_is_ack;
            r_tgt      <= n_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (w_en) begin
                r_store[w_idx] <= i_byte;
            end
            // last three bytes for the tail match
            r_b3 <= r_b2;
            r_b2 <= r_b1;
            r_b1 <= i_byte;
        end
    end

    assign o_target = r_tgt;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_FRAME))
        else $error("byte position beyond frame limit");

    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> r_pos == '0)
        else $error("idle parser holds a byte position");

    a_toolong_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_event == EV_TOOLONG) |-> r_pos == PW'(LEN_CHECK_POS - 1))
        else $error("length drop away from length byte");

    a_accept_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_event == EV_ACCEPT) |=> r_tgt.length >= ALEN_W'(MIN_DATA_LEN))
        else $error("accepted frame shorter than payload");

    a_ack_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_event != EV_ACCEPT) |=> $stable(r_tgt))
        else $error("target registers changed without accepted frame");

endmodule

@@ tb/sv/rfp_result_checker.sv @@
// result checker for the radar frame parser: predicts every result beat and compares it
`timescale 1ns / 100ps
module rfp_result_checker
    import rfp_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rfp_byte_if   i_byte,
    rfp_result_if i_result,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_event_count [6]
);

    typedef struct packed {
        t_event            ev;
        logic [7:0]        kind;
        logic [15:0]       moving_dist;
        logic [6:0]        moving_energy;
        logic [15:0]       still_dist;
        logic [7:0]        still_energy;
        logic              presence;
        logic              moving_seen;
        logic              still_seen;
        logic [ALEN_W-1:0] length;
    } t_parse_out;

    logic [7:0] frame_bytes [MAX_FRAME];
    int         frame_pos;
    logic       framing;
    logic       ack_frame;
    t_target    targets;
    t_parse_out expected_results [$];

    int fail_count = 0;
    int pending_count = 0;
    int event_count [6] = '{default: 0};

    assign o_fail_count  = fail_count;
    assign o_pending     = pending_count;
    assign o_event_count = event_count;

    function automatic logic [7:0] frame_byte(input int idx);
        return (idx < MAX_FRAME) ? frame_bytes[idx] : 8'h00;
    endfunction

    function automatic logic match4(input int base, input logic [7:0] b0,
                                    input logic [7:0] b1, input logic [7:0] b2,
                                    input logic [7:0] b3);
        return frame_byte(base) == b0 && frame_byte(base + 1) == b1 &&
               frame_byte(base + 2) == b2 && frame_byte(base + 3) == b3;
    endfunction

    // advances the frame state by one byte and returns the event it causes
    function automatic t_event parse_rx_byte(input logic [7:0] rx);
        int     len_field;
        int     tail;
        t_event ev;
        if (!framing) begin
            if (rx == DATA_H0 || rx == ACK_H0) begin
                frame_bytes[0] = rx;
                frame_pos      = 1;
                framing        = 1'b1;
                ack_frame      = (rx == ACK_H0);
            end
            return EV_NONE;
        end
        if (frame_pos >= MAX_FRAME || frame_pos == 0) begin
            framing   = 1'b0;
            frame_pos = 0;
            return EV_OVERRUN;
        end
        frame_bytes[frame_pos] = rx;
        frame_pos++;
        len_field = {frame_byte(5), frame_byte(4)};
        tail      = frame_pos - 4;
        ev        = EV_NONE;
        if (frame_pos == LEN_CHECK_POS && len_field + LEN_OVERHEAD > MAX_FRAME) begin
            ev = EV_TOOLONG;
        end else if (frame_pos >= LEN_CHECK_POS && ack_frame &&
                     match4(0, ACK_H0, ACK_H1, ACK_H2, ACK_H3) &&
                     match4(tail, ACK_T0, ACK_T1, ACK_T2, ACK_T3)) begin
            ev = EV_ACK;
        end else if (frame_pos >= LEN_CHECK_POS && !ack_frame &&
                     match4(0, DATA_H0, DATA_H1, DATA_H2, DATA_H3) &&
                     match4(tail, DATA_T0, DATA_T1, DATA_T2, DATA_T3)) begin
            if (frame_pos == len_field + LEN_OVERHEAD && frame_pos >= MIN_DATA_LEN &&
                frame_byte(6) == MARK_6 && frame_byte(7) == MARK_7 &&
                frame_byte(17) == MARK_17 && frame_byte(18) == MARK_18) begin
                ev                    = EV_ACCEPT;
                targets.kind          = frame_byte(8);
                targets.still_dist    = {frame_byte(10), frame_byte(9)};
                targets.moving_dist   = {frame_byte(16), frame_byte(15)};
                targets.still_energy  = frame_byte(14);
                targets.moving_energy = frame_byte(11);
                targets.length        = ALEN_W'(frame_pos);
            end else begin
                ev = EV_REJECT;
            end
        end else if (frame_pos >= MAX_FRAME) begin
            ev = EV_OVERRUN;
        end
        if (ev != EV_NONE) begin
            framing   = 1'b0;
            frame_pos = 0;
        end
        return ev;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (seen !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_parse_out want;
        t_event     ev;
        if (!i_rst_n) begin
            foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
            frame_pos = 0;
            framing   = 1'b0;
            ack_frame = 1'b0;
            targets   = '0;
            expected_results.delete();
        end else begin
            if (i_result.valid === 1'b1 && i_result.ready === 1'b1) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat expected none actual event %0h",
                             $time, i_result.event_res);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    event_count[want.ev]++;
                    check_field("event_res", want.ev, i_result.event_res);
                    check_field("target_kind", want.kind, i_result.target_kind);
                    check_field("moving_distance", want.moving_dist, i_result.moving_distance);
                    check_field("moving_energy", want.moving_energy, i_result.moving_energy);
                    check_field("still_distance", want.still_dist, i_result.still_distance);
                    check_field("still_energy", want.still_energy, i_result.still_energy);
                    check_field("presence", want.presence, i_result.presence);
                    check_field("moving_seen", want.moving_seen, i_result.moving_seen);
                    check_field("still_seen", want.still_seen, i_result.still_seen);
                    check_field("accepted_length", want.length, i_result.accepted_length);
                end
            end
            if (i_byte.valid === 1'b1 && i_byte.ready === 1'b1) begin
                ev                 = parse_rx_byte(i_byte.rx_byte);
                want.ev            = ev;
                want.kind          = targets.kind;
                want.moving_dist   = targets.moving_dist;
                want.moving_energy = (targets.moving_energy > ENERGY_MAX) ?
                                     7'(ENERGY_MAX) : targets.moving_energy[6:0];
                want.still_dist    = targets.still_dist;
                want.still_energy  = targets.still_energy;
                want.presence      = (targets.kind != 8'h00);
                // raw energy decides the seen flag, not the clamped one
                want.moving_seen   = targets.kind[0] && targets.moving_dist != 16'h0 &&
                                     targets.moving_energy != 8'h00;
                want.still_seen    = targets.kind[1] && targets.still_dist != 16'h0 &&
                                     targets.still_energy != 8'h00;
                want.length        = targets.length;
                expected_results.push_back(want);
            end
        end
        pending_count = expected_results.size();
    end

endmodule

@@ tb/sv/tb_radar_frame_parser.sv @@
// testbench top for the radar frame parser: clock, reset, byte stimulus and verdict
`timescale 1ns / 100ps
module tb_radar_frame_parser;
    import rfp_pkg::*;

    localparam int      CLK_PERIOD      = 10;
    localparam int      HOLD_OFF_CYCLES = 300;
    localparam int      RANDOM_BYTES    = 1750;
    localparam int      CALM_BYTES      = 250;
    localparam longint  RUN_LIMIT_NS    = 5_000_000;

    typedef enum {
        SHAPE_DATA_GOOD,
        SHAPE_DATA_BAD,
        SHAPE_ACK,
        SHAPE_TOO_LONG,
        SHAPE_OVERRUN,
        SHAPE_CUT,
        SHAPE_NOISE
    } t_frame_shape;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rfp_byte_if   byte_ch ();
    rfp_result_if result_ch ();

    int fail_count;
    int pending;
    int event_count [6];

    int         idle_pct     = 0;
    int         stall_pct    = 0;
    bit         hold_off_req = 1'b0;
    int         bytes_sent   = 0;
    int         frames_sent  = 0;
    logic [7:0] tx_q [$];

    radar_frame_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    rfp_result_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte        (byte_ch),
        .i_result      (result_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_event_count (event_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // payload byte that often sits on a boundary: zero, full scale, energy clamp edge
    function automatic logic [7:0] field_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'(ENERGY_MAX + $urandom_range(0, 1));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void queue_data_frame(input int total, input logic [15:0] len_field,
                                             input logic [7:0] m6, input logic [7:0] m7,
                                             input logic [7:0] m17, input logic [7:0] m18);
        tx_q.push_back(DATA_H0);
        tx_q.push_back(DATA_H1);
        tx_q.push_back(DATA_H2);
        tx_q.push_back(DATA_H3);
        tx_q.push_back(len_field[7:0]);
        tx_q.push_back(len_field[15:8]);
        tx_q.push_back(m6);
        tx_q.push_back(m7);
        for (int i = 8; i < total - 4; i++) begin
            case (i)
                8:       tx_q.push_back(($urandom_range(0, 4) == 0) ?
                                        8'($urandom) : 8'($urandom_range(0, 3)));
                17:      tx_q.push_back(m17);
                18:      tx_q.push_back(m18);
                default: tx_q.push_back(field_byte());
            endcase
        end
        tx_q.push_back(DATA_T0);
        tx_q.push_back(DATA_T1);
        tx_q.push_back(DATA_T2);
        tx_q.push_back(DATA_T3);
    endfunction

    function automatic logic [7:0] flip_bit(input logic [7:0] value);
        return value ^ (8'h01 << $urandom_range(0, 7));
    endfunction

    function automatic t_frame_shape pick_shape();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return SHAPE_DATA_GOOD;
        if (roll < 55) return SHAPE_ACK;
        if (roll < 67) return SHAPE_DATA_BAD;
        if (roll < 75) return SHAPE_TOO_LONG;
        if (roll < 83) return SHAPE_OVERRUN;
        if (roll < 92) return SHAPE_CUT;
        return SHAPE_NOISE;
    endfunction

    function automatic void queue_frame(input t_frame_shape shape);
        int total;
        int len;
        case (shape)
            SHAPE_DATA_GOOD: begin
                // 23 is the shortest frame whose tail clears the markers at bytes 17 and 18
                total = $urandom_range(23, MAX_FRAME_DEF);
                queue_data_frame(total, 16'(total - LEN_OVERHEAD),
                                 MARK_6, MARK_7, MARK_17, MARK_18);
            end
            SHAPE_DATA_BAD: begin
                case ($urandom_range(0, 2))
                    0: begin
                        total = $urandom_range(23, MAX_FRAME_DEF - 1);
                        len   = total - LEN_OVERHEAD + (($urandom_range(0, 1) != 0) ? 1 : -1);
                        queue_data_frame(total, 16'(len), MARK_6, MARK_7, MARK_17, MARK_18);
                    end
                    1: begin
                        total = $urandom_range(23, MAX_FRAME_DEF);
                        len   = total - LEN_OVERHEAD;
                        case ($urandom_range(0, 3))
                            0: queue_data_frame(total, 16'(len), flip_bit(MARK_6), MARK_7,
                                                MARK_17, MARK_18);
                            1: queue_data_frame(total, 16'(len), MARK_6, flip_bit(MARK_7),
                                                MARK_17, MARK_18);
                            2: queue_data_frame(total, 16'(len), MARK_6, MARK_7,
                                                flip_bit(MARK_17), MARK_18);
                            default: queue_data_frame(total, 16'(len), MARK_6, MARK_7,
                                                      MARK_17, flip_bit(MARK_18));
                        endcase
                    end
                    default: begin
                        // length matches but the frame is too short to hold its markers
                        total = $urandom_range(12, 22);
                        queue_data_frame(total, 16'(total - LEN_OVERHEAD),
                                         MARK_6, MARK_7, MARK_17, MARK_18);
                    end
                endcase
            end
            SHAPE_ACK: begin
                tx_q.push_back(ACK_H0);
                tx_q.push_back(ACK_H1);
                tx_q.push_back(ACK_H2);
                tx_q.push_back(ACK_H3);
                tx_q.push_back(8'($urandom_range(0, MAX_FRAME_DEF - LEN_OVERHEAD)));
                tx_q.push_back(8'h00);
                repeat ($urandom_range(2, MAX_FRAME_DEF - 10)) tx_q.push_back(field_byte());
                tx_q.push_back(ACK_T0);
                tx_q.push_back(ACK_T1);
                tx_q.push_back(ACK_T2);
                tx_q.push_back(ACK_T3);
            end
            SHAPE_TOO_LONG: begin
                tx_q.push_back(($urandom_range(0, 1) != 0) ? DATA_H0 : ACK_H0);
                repeat (3) tx_q.push_back(8'($urandom));
                case ($urandom_range(0, 2))
                    0: begin
                        tx_q.push_back(8'(MAX_FRAME_DEF - LEN_OVERHEAD + 1));
                        tx_q.push_back(8'h00);
                    end
                    1: begin
                        tx_q.push_back(8'($urandom_range(MAX_FRAME_DEF - LEN_OVERHEAD + 1,
                                                         255)));
                        tx_q.push_back(8'h00);
                    end
                    default: begin
                        tx_q.push_back(8'($urandom));
                        tx_q.push_back(8'($urandom_range(1, 255)));
                    end
                endcase
                repeat (2) tx_q.push_back(8'($urandom));
            end
            SHAPE_OVERRUN: begin
                if ($urandom_range(0, 1) != 0) begin
                    tx_q.push_back(DATA_H0);
                    tx_q.push_back(DATA_H1);
                    tx_q.push_back(DATA_H2);
                    tx_q.push_back(DATA_H3);
                end else begin
                    tx_q.push_back(ACK_H0);
                    tx_q.push_back(ACK_H1);
                    tx_q.push_back(ACK_H2);
                    tx_q.push_back(ACK_H3);
                end
                tx_q.push_back(8'($urandom_range(0, MAX_FRAME_DEF - LEN_OVERHEAD)));
                tx_q.push_back(8'h00);
                repeat (MAX_FRAME_DEF - 6) tx_q.push_back(field_byte());
            end
            SHAPE_CUT: begin
                total = $urandom_range(23, MAX_FRAME_DEF);
                queue_data_frame(total, 16'(total - LEN_OVERHEAD),
                                 MARK_6, MARK_7, MARK_17, MARK_18);
                repeat ($urandom_range(1, total - 1)) void'(tx_q.pop_back());
            end
            default: begin
                repeat ($urandom_range(1, 6)) tx_q.push_back(8'($urandom));
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] value);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= value;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_queued();
        foreach (tx_q[i]) send_byte(tx_q[i]);
        tx_q.delete();
        frames_sent++;
    endtask

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        int low_left;
        low_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                low_left     = HOLD_OFF_CYCLES;
            end else if (low_left == 0 && stall_pct != 0 &&
                         $urandom_range(0, 99) < stall_pct) begin
                low_left = $urandom_range(1, 14);
            end
            if (low_left > 0) begin
                result_ch.ready <= 1'b0;
                low_left--;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_choice [3];
        idle_choice = '{0, 10, 30};
        byte_ch.valid   <= 1'b0;
        byte_ch.rx_byte <= 8'h00;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one ignored idle byte, then an accepted frame with every field at full scale
        tx_q = '{8'hFF, DATA_H0, DATA_H1, DATA_H2, DATA_H3, 8'd13, 8'h00, MARK_6, MARK_7,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 MARK_17, MARK_18, DATA_T0, DATA_T1, DATA_T2, DATA_T3};
        send_queued();

        // long hold-off first: the sender keeps offering so the input backs up
        hold_off_req = 1'b1;
        queue_frame(SHAPE_DATA_GOOD);
        send_queued();

        while (bytes_sent < RANDOM_BYTES) begin
            if (bytes_sent >= RANDOM_BYTES - CALM_BYTES) begin
                idle_pct  = 0;
                stall_pct = 0;
            end else begin
                idle_pct  = idle_choice[$urandom_range(0, 2)];
                stall_pct = idle_choice[$urandom_range(0, 2)];
            end
            queue_frame(pick_shape());
            send_queued();
        end
        byte_ch.valid <= 1'b0;

        @(negedge i_clk);
        wait (pending == 0);
        repeat (8) @(posedge i_clk);

        $display("sent %0d bytes in %0d frames and fragments, with a %0d-cycle result hold-off",
                 bytes_sent, frames_sent, HOLD_OFF_CYCLES);
        $display("events checked: %0d accepted, %0d ack, %0d rejected, %0d too long, %0d overrun",
                 event_count[EV_ACCEPT], event_count[EV_ACK], event_count[EV_REJECT],
                 event_count[EV_TOOLONG], event_count[EV_OVERRUN]);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_radar_frame_parser: PASS");
        end else begin
            $display("tb_radar_frame_parser: FAIL");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout at %0t with %0d results outstanding", $time, pending);
        $display("tb_radar_frame_parser: FAIL");
        $finish;
    end

endmodule
